FILE: sv/sorted_byte_list_macros.svh
// Assertion macros shared by the sorted byte list RTL.
`ifndef SORTED_BYTE_LIST_MACROS_SVH
`define SORTED_BYTE_LIST_MACROS_SVH

`ifndef ASSERT_OFF

`define SBL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sorted_byte_list: assertion failed");

`define SBL_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("sorted_byte_list: forbidden condition seen");

`else

`define SBL_ASSERT(label, clk, rst_n, prop)
`define SBL_ASSERT_NEVER(label, clk, rst_n, prop)

`endif

`endif

FILE: sv/sbl_pkg.sv
// Package with the sizes, command codes and status codes of the sorted byte list.
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 8;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

FILE: sv/sorted_byte_list.sv
// Top level of the sorted byte list: sequencer, count register and result register.
// The block keeps up to CAPACITY signed bytes in ascending order in a small memory and
// handles one item at a time. An insert scans down from the last entry, moving every
// entry that is not smaller than the new value up by one place, one entry per cycle
// through the shared comparator. A delete scans up from the first entry and closes the
// gap behind the match in the same pass. The memory's single read port sets the pace
// of one entry per cycle. The result waits in an output register, so the next item is
// taken while it is held.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_byte_list_macros.svh"

module sorted_byte_list
  import sbl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic [POS_W-1:0]    position_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic [COUNT_W-1:0]       count_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic              found_q, found_d;
  logic [CMD_W-1:0]  op_q, op_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [VAL_W-1:0]  rv_q, rv_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_rv_q, out_rv_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [VAL_W-1:0]  wdata;
  logic [IDX_W-1:0]  raddr;
  logic [VAL_W-1:0]  rdata;
  cmp_t              cmp;

  logic              accept;
  logic              slot_free;
  logic              full;
  logic              last;
  logic              pos_ok;
  logic [IDX_W-1:0]  top_idx;

  sbl_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sbl_cmp u_cmp (
    .stored_i (rdata),
    .key_i    (val_q),
    .res_o    (cmp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign top_idx    = IDX_W'(count_q - CNT_W'(1));
  assign last       = (ptr_q == top_idx);
  assign pos_ok     = (position_i != '0) && (32'(position_i) <= 32'(count_q));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    found_d      = found_q;
    op_d         = op_q;
    val_d        = val_q;
    st_d         = st_q;
    rv_d         = rv_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_rv_d     = out_rv_q;
    out_count_d  = out_count_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = val_q;
    raddr        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = cmd_i;
          val_d = value_i;
          rv_d  = '0;
          st_d  = ST_MISS;
          unique case (cmd_i)
            CMD_INSERT: begin
              if (full) begin
                st_d    = ST_FULL;
                state_d = S_FIN;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = value_i;
                st_d    = ST_DONE;
                state_d = S_FIN;
              end else begin
                raddr   = top_idx;
                ptr_d   = top_idx;
                state_d = S_INS;
              end
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                state_d = S_FIN;
              end else begin
                raddr   = '0;
                ptr_d   = '0;
                found_d = 1'b0;
                state_d = S_DEL;
              end
            end
            CMD_READ: begin
              if (pos_ok) begin
                raddr   = IDX_W'(position_i - POS_W'(1));
                state_d = S_RD;
              end else begin
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = ptr_q + IDX_W'(1);
        raddr = ptr_q - IDX_W'(1);
        if (cmp.lt) begin
          wdata   = val_q;
          st_d    = ST_DONE;
          state_d = S_FIN;
        end else begin
          wdata = rdata;
          if (ptr_q == '0) begin
            state_d = S_INS0;
          end else begin
            ptr_d = ptr_q - IDX_W'(1);
          end
        end
      end
      S_INS0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        st_d    = ST_DONE;
        state_d = S_FIN;
      end
      S_DEL: begin
        raddr = ptr_q + IDX_W'(1);
        if (found_q) begin
          we    = 1'b1;
          waddr = ptr_q - IDX_W'(1);
          wdata = rdata;
        end else if (cmp.eq) begin
          found_d = 1'b1;
        end
        if (last) begin
          st_d    = (found_q || cmp.eq) ? ST_DONE : ST_MISS;
          state_d = S_FIN;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      S_RD: begin
        rv_d    = rdata;
        st_d    = ST_DONE;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          if (st_q == ST_DONE && op_q == CMD_INSERT) begin
            count_d = count_q + CNT_W'(1);
          end else if (st_q == ST_DONE && op_q == CMD_DELETE) begin
            count_d = count_q - CNT_W'(1);
          end
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_rv_d     = rv_q;
          out_count_d  = COUNT_W'(count_d);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    op_q         <= op_d;
    val_q        <= val_d;
    st_q         <= st_d;
    rv_q         <= rv_d;
    out_status_q <= out_status_d;
    out_rv_q     <= out_rv_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_rv_q;
  assign count_o      = out_count_q;

  `SBL_ASSERT(a_count_bound, clk_i, rst_ni, (count_q <= CNT_W'(CAPACITY)))
  `SBL_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, (accept |=> (state_q != S_IDLE)))
  `SBL_ASSERT(a_del_ptr_in_range, clk_i, rst_ni, ((state_q == S_DEL) |-> (ptr_q <= top_idx)))
  `SBL_ASSERT_NEVER(a_full_with_room, clk_i, rst_ni,
                    (out_valid_o && status_o == ST_FULL && count_o != COUNT_W'(CAPACITY)))

endmodule

`default_nettype wire

FILE: sv/sbl_ram.sv
// Storage array for the sorted values with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sbl_ram
  import sbl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/sbl_cmp.sv
// Shared signed comparator used by the insert and delete scans.
`timescale 1ns / 1ps
`default_nettype none

module sbl_cmp
  import sbl_pkg::*;
(
  input  wire logic signed [VAL_W-1:0] stored_i,
  input  wire logic signed [VAL_W-1:0] key_i,
  output cmp_t                         res_o
);

  always_comb begin
    res_o.lt = (stored_i < key_i);
    res_o.eq = (stored_i == key_i);
  end

endmodule

`default_nettype wire
